FILE: sv/pkm_pkg.sv
// shared types, constants and register indexes for the keyword matcher
// no dependencies; imported by every module of the block
`default_nettype none

package pkm_pkg;

    localparam int TAG_MAX    = 32;
    localparam int KW_WORDS   = 4;
    localparam int KW_BYTES   = KW_WORDS * 8;
    localparam int LEN_W      = $clog2(TAG_MAX + 1);
    localparam int LEN_CMP_W  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LEN_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_KW_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_TOP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_LEN = 3'd4;

    localparam logic [7:0] CHR_NUL  = 8'h00;
    localparam logic [7:0] CHR_ESC  = 8'h1B;
    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_LBRK = 8'h5B;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef logic [TAG_MAX-1:0][7:0] kw_array_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic halted;
    } out_item_t;

    // classification of the byte in the input register
    typedef struct packed {
        logic [7:0] chr;
        logic       is_nul;
        logic       is_skip;
        logic       esc_cont;
        logic       is_esc;
    } byte_class_t;

    typedef struct packed {
        logic pending;
        logic halted;
        logic matched;
        logic in_escape;
        logic trail;
    } core_status_t;

endpackage

`default_nettype wire

FILE: sv/punctuation_tolerant_keyword_matcher.sv
// top level of the keyword matcher: input register, match core, result register
// depends on pkm_pkg, pkm_cfg_regs, pkm_byte_class, pkm_match_core
//
// channel  direction  handshake           payload
// s_       in         s_valid / s_ready   s_item  (data_byte, end_of_data)
// m_       out        m_valid / m_ready   m_item  (found, halted)
// cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// one byte per cycle sustained while m_ready stays high; a byte waits in the input
// register, and its result is captured in the result register that drives m_. The
// state update is a single pass of 32 byte compares feeding the partial match vector.
// aresetn is synchronous; it clears the stream state and sets keyword length to one.
// a stalled m_ holds one result, and the input register takes one more byte.
`default_nettype none

module punctuation_tolerant_keyword_matcher
    import pkm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    in_item_t     in_item_reg;
    logic         in_valid_reg;
    out_item_t    out_item_reg;
    logic         out_valid_reg;
    logic         advance;
    kw_array_t    kw_bytes;
    logic [LEN_W-1:0] kw_len;
    byte_class_t  cls;
    out_item_t    result;
    core_status_t status;

    // the held byte moves on whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    pkm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .kw_bytes  (kw_bytes),
        .kw_len    (kw_len)
    );

    pkm_byte_class u_class (
        .data_byte (in_item_reg.data_byte),
        .trail     (status.trail),
        .cls       (cls)
    );

    pkm_match_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .end_of_data (in_item_reg.end_of_data),
        .data_byte   (in_item_reg.data_byte),
        .cls         (cls),
        .kw_bytes    (kw_bytes),
        .kw_len      (kw_len),
        .result      (result),
        .status      (status)
    );

`ifndef SYNTHESIS
    // the last byte of a stream leaves every stream flag clear
    a_eod_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.end_of_data |=>
            !status.pending && !status.halted && !status.matched
            && !status.in_escape && !status.trail)
        else $error("stream state not cleared after end of data");

    // a halted search keeps no pending prefixes
    a_halt_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        status.halted |-> !status.pending)
        else $error("pending prefixes while halted");

    // an empty result register never blocks the input side
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with result register empty");

    // a result with the halted flag follows the previous one within a stream
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && status.halted |-> result.halted)
        else $error("halted flag dropped within a stream");
`endif

endmodule

`default_nettype wire

FILE: sv/pkm_cfg_regs.sv
// configuration registers: keyword words and keyword length
// depends on pkm_pkg; presents keyword bytes and the clamped length
`default_nettype none

module pkm_cfg_regs
    import pkm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output kw_array_t                  kw_bytes,
    output logic [LEN_W-1:0]           kw_len
);

    logic [KW_WORDS-1:0][CFG_DATA_W-1:0] kw_word_reg;
    logic [CFG_LEN_W-1:0]                kw_len_reg;
    logic [LEN_CMP_W-1:0]                len_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_word_reg <= '0;
            kw_len_reg  <= CFG_LEN_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KW_LO:  kw_word_reg[0] <= cfg_wdata;
                CFG_KW_MID: kw_word_reg[1] <= cfg_wdata;
                CFG_KW_HI:  kw_word_reg[2] <= cfg_wdata;
                CFG_KW_TOP: kw_word_reg[3] <= cfg_wdata;
                CFG_KW_LEN: kw_len_reg     <= cfg_wdata[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the tag limit as the limit
    always_comb begin
        len_wide = LEN_CMP_W'(kw_len_reg);
        if (len_wide == '0) begin
            len_wide = LEN_CMP_W'(1);
        end else if (len_wide > LEN_CMP_W'(TAG_MAX)) begin
            len_wide = LEN_CMP_W'(TAG_MAX);
        end
        kw_len = len_wide[LEN_W-1:0];
    end

    for (genvar k = 0; k < TAG_MAX; k++) begin : g_kw
        if (k < KW_BYTES) begin : g_real
            assign kw_bytes[k] = kw_word_reg[k/8][(k%8)*8 +: 8];
        end else begin : g_zero
            assign kw_bytes[k] = 8'h00;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pkm_byte_class.sv
// byte classifier: case folding, skip set, escape continuation
// depends on pkm_pkg; purely combinational
`default_nettype none

module pkm_byte_class
    import pkm_pkg::*;
(
    input  wire logic [7:0] data_byte,
    input  wire logic       trail,
    output byte_class_t     cls
);

    logic [7:0] chr;

    always_comb begin
        chr = data_byte;
        // trail bytes of a double-byte character are never folded
        if (!trail && data_byte >= "A" && data_byte <= "Z") begin
            chr = data_byte | CASE_BIT;
        end

        cls.chr    = chr;
        cls.is_nul = (data_byte == CHR_NUL);
        cls.is_esc = (chr == CHR_ESC);

        case (chr) inside
            8'h0A, [8'h20:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]:
                cls.is_skip = 1'b1;
            default:
                cls.is_skip = 1'b0;
        endcase

        cls.esc_cont = (chr >= "0" && chr <= "9") || chr == CHR_SEMI || chr == CHR_LBRK;
    end

endmodule

`default_nettype wire

FILE: sv/pkm_match_core.sv
// match state: partial match vector, sticky flags, double-byte and escape tracking
// depends on pkm_pkg; fed by pkm_byte_class and pkm_cfg_regs
`default_nettype none

module pkm_match_core
    import pkm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             end_of_data,
    input  wire logic [7:0]       data_byte,
    input  wire byte_class_t      cls,
    input  wire kw_array_t        kw_bytes,
    input  wire logic [LEN_W-1:0] kw_len,
    output out_item_t             result,
    output core_status_t          status
);

    logic [TAG_MAX-1:0] partial_reg, partial_next;
    logic               match_reg, match_next;
    logic               halted_reg, halted_next;
    logic               trail_reg, trail_next;
    logic               escape_reg, escape_next;
    logic [TAG_MAX-1:0] scan_vec;
    logic               hit;

    always_comb begin
        partial_next = partial_reg;
        match_next   = match_reg;
        halted_next  = halted_reg;
        trail_next   = trail_reg;
        escape_next  = escape_reg;
        scan_vec     = '0;
        hit          = 1'b0;

        if (!halted_reg) begin
            if (cls.is_nul) begin
                halted_next  = 1'b1;
                partial_next = '0;
            end else begin
                trail_next = trail_reg ? 1'b0 : data_byte[7];

                if (escape_reg) begin
                    if (!cls.esc_cont) begin
                        escape_next = 1'b0;
                    end
                    scan_vec = partial_reg;
                end else if (cls.is_esc && partial_reg != '0) begin
                    escape_next = 1'b1;
                    scan_vec    = partial_reg;
                end else begin
                    // every pending prefix advances, holds on a skip byte or dies
                    for (int i = 0; i < TAG_MAX - 1; i++) begin
                        if (partial_reg[i] && (i + 1) < int'(kw_len)) begin
                            if (cls.chr == kw_bytes[i+1]) begin
                                if ((i + 2) == int'(kw_len)) begin
                                    hit = 1'b1;
                                end else begin
                                    scan_vec[i+1] = 1'b1;
                                end
                            end else if (cls.is_skip) begin
                                scan_vec[i] = 1'b1;
                            end
                        end
                    end
                end

                // a new start needs a lead or single byte outside an escape
                if (!trail_reg && !escape_reg && cls.chr == kw_bytes[0]) begin
                    if (kw_len == LEN_W'(1)) begin
                        hit = 1'b1;
                    end else begin
                        scan_vec[0] = 1'b1;
                    end
                end

                partial_next = scan_vec;
                match_next   = match_reg | hit;
            end
        end
    end

    assign result.found  = match_next;
    assign result.halted = halted_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            match_reg   <= 1'b0;
            halted_reg  <= 1'b0;
            trail_reg   <= 1'b0;
            escape_reg  <= 1'b0;
        end else if (advance) begin
            if (end_of_data) begin
                partial_reg <= '0;
                match_reg   <= 1'b0;
                halted_reg  <= 1'b0;
                trail_reg   <= 1'b0;
                escape_reg  <= 1'b0;
            end else begin
                partial_reg <= partial_next;
                match_reg   <= match_next;
                halted_reg  <= halted_next;
                trail_reg   <= trail_next;
                escape_reg  <= escape_next;
            end
        end
    end

    assign status.pending   = (partial_reg != '0);
    assign status.halted    = halted_reg;
    assign status.matched   = match_reg;
    assign status.in_escape = escape_reg;
    assign status.trail     = trail_reg;

endmodule

`default_nettype wire
